@@ src/lnr_pkg.sv @@
// ----------------------------------------------------------------------------
// lnr_pkg - shared types and constants for the layer normalization block
// Item structs, command and register codes, and internal datapath widths.
// ----------------------------------------------------------------------------
package lnr_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int MAX_ROW_DEF = 64;
  localparam int POS_W       = 6;
  localparam int LEN_W       = 7;
  localparam int RECIP_W     = 16;
  localparam int SUM_W       = 24;
  localparam int SUMSQ_W     = 39;
  localparam int VAR_W       = 40;
  localparam int QUO_W       = 49;
  localparam int ROOT_W      = 25;
  localparam int CFG_IDX_W   = 2;

  localparam logic [LEN_W-1:0]   ROW_LENGTH_RST = 7'd64;
  localparam logic [RECIP_W-1:0] RECIP_RST      = 16'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_LEN  = 2'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PUSH = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [POS_W-1:0]              position;
    logic signed [DATA_WIDTH-1:0]  data_value;
    logic signed [DATA_WIDTH-1:0]  weight_value;
    logic signed [DATA_WIDTH-1:0]  bias_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  out_value;
    logic [POS_W-1:0]              out_position;
    logic                          row_done;
  } out_item_t;

endpackage

@@ src/layer_norm_row.sv @@
// ----------------------------------------------------------------------------
// layer_norm_row - layer normalization over one row of Q8.8 elements
// Loads per-position weight and bias, collects a row, then emits
// weight*(x-mean)*rsqrt(var+eps)+bias for every position, saturated.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload       Flow control
//  --------  -------------------  ------------  ------------------------------
//  input     start && !busy       in_item       busy holds items off
//  result    out_valid strobe     out_item      one cycle, cannot be stalled
//  config    cfg_we               cfg_index/    taken at once; user writes at idle time only
//                                 cfg_data      (the block does not enforce this)
//
// A load item or a push that does not complete the row leaves the block idle
// and ready for the next item. The push that completes a row of n elements
// starts the mean (S_MEAN, S_MEAN2), a variance pass over the elements (S_VRD,
// S_VMUL, S_VACC), the variance scaling (S_VSCALE, S_VSET), the inverse square
// root unit (a start step, 49 divide steps, 25 root steps and a done step) and
// an output pass (S_ERD, S_EM1, S_EM2, S_EM3); the passes use the one shared
// multiplier. Results leave one per element and the receiver cannot stall
// them; the last one is shown in the first cycle the block is free again.
// Reset clears the state, fill count, running sum and valid flags, sets the
// config registers to defaults; the weight, bias and row stores are not cleared.

module layer_norm_row #(
  parameter int MAX_ROW = lnr_pkg::MAX_ROW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  lnr_pkg::in_item_t              in_item,
  output logic                           out_valid,
  output lnr_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [lnr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lnr_pkg::RECIP_W-1:0]    cfg_data
);

  localparam int IW = $clog2(MAX_ROW);
  localparam int DW = lnr_pkg::DATA_WIDTH;
  localparam int LW = lnr_pkg::LEN_W;
  localparam int AW = 43;
  localparam int BW = 18;
  localparam int PW = AW + BW;
  localparam int NPOS = 2 ** lnr_pkg::POS_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MEAN   = 4'd1;
  localparam logic [3:0] S_MEAN2  = 4'd2;
  localparam logic [3:0] S_VRD    = 4'd3;
  localparam logic [3:0] S_VMUL   = 4'd4;
  localparam logic [3:0] S_VACC   = 4'd5;
  localparam logic [3:0] S_VSCALE = 4'd6;
  localparam logic [3:0] S_VSET   = 4'd7;
  localparam logic [3:0] S_RSQ    = 4'd8;
  localparam logic [3:0] S_ERD    = 4'd9;
  localparam logic [3:0] S_EM1    = 4'd10;
  localparam logic [3:0] S_EM2    = 4'd11;
  localparam logic [3:0] S_EM3    = 4'd12;

  // Position wrap table: a load position folds onto the store depth.
  logic [IW-1:0] pos_wrap [NPOS];
  for (genvar g = 0; g < NPOS; g++) begin : g_wrap
    assign pos_wrap[g] = IW'(g % MAX_ROW);
  end

  // Configuration registers.
  logic [LW-1:0]                row_length_r;
  logic [lnr_pkg::RECIP_W-1:0]  recip_r;

  // Sequencer and datapath registers.
  logic [3:0]                   state_r, state_nxt;
  logic [IW-1:0]                fill_r, fill_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic [LW-1:0]                n_r, n_nxt;
  logic signed [lnr_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [lnr_pkg::SUMSQ_W-1:0]  sumsq_r, sumsq_nxt;
  logic signed [DW-1:0]         mean_r, mean_nxt;
  logic [lnr_pkg::ROOT_W-1:0]   r_r, r_nxt;
  logic [lnr_pkg::VAR_W-1:0]    v_r, v_nxt;
  logic                         rsq_start_r, rsq_start_nxt;
  logic signed [PW-1:0]         mul_p_r;
  logic                         out_valid_r, out_valid_nxt;
  lnr_pkg::out_item_t           out_item_r, out_item_nxt;

  // Stores, each written at one address and read through a registered port.
  logic signed [DW-1:0] row_mem    [MAX_ROW];
  logic signed [DW-1:0] scale_mem  [MAX_ROW];
  logic signed [DW-1:0] offset_mem [MAX_ROW];
  logic signed [DW-1:0] row_q, scale_q, offset_q;

  logic                 accept, push, load, rd_en, last_idx;
  logic [LW-1:0]        len_eff;
  logic signed [DW:0]   d;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p, rnd, shv;
  logic                 rsq_done;
  logic [lnr_pkg::ROOT_W-1:0] rsq_root;

  assign accept = start && !busy;
  assign push   = accept && (in_item.command == lnr_pkg::CMD_PUSH);
  assign load   = accept && (in_item.command == lnr_pkg::CMD_LOAD);
  assign rd_en  = (state_r == S_VRD) || (state_r == S_ERD);

  // A row length of zero acts as one, and lengths past the store depth clip.
  always_comb begin
    if (row_length_r == '0) begin
      len_eff = LW'(1);
    end else if (row_length_r > LW'(MAX_ROW)) begin
      len_eff = LW'(MAX_ROW);
    end else begin
      len_eff = row_length_r;
    end
  end

  assign d        = (DW+1)'(row_q) - (DW+1)'(mean_r);
  assign last_idx = (LW'(idx_r) + LW'(1)) == n_r;

  // The one shared multiplier: operands are steered by the sequencer state and
  // the product is always registered before it is used.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MEAN: begin
        mul_a = AW'(sum_r);
        mul_b = $signed({2'b00, recip_r});
      end
      S_VMUL: begin
        mul_a = AW'(d);
        mul_b = BW'(d);
      end
      S_VSCALE: begin
        mul_a = $signed({4'b0000, sumsq_r});
        mul_b = $signed({2'b00, recip_r});
      end
      S_EM1: begin
        mul_a = $signed({18'd0, r_r});
        mul_b = BW'(d);
      end
      S_EM2: begin
        mul_a = mul_p_r[AW-1:0];
        mul_b = BW'(scale_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounding and floor shift for the mean, the variance and the output value.
  always_comb begin
    if (state_r == S_EM3) begin
      rnd = mul_p_r + PW'(64'sd8388608);
      shv = (rnd >>> 24) + PW'(offset_q);
    end else begin
      rnd = mul_p_r + PW'(64'sd32768);
      shv = rnd >>> 16;
    end
  end

  function automatic logic signed [DW-1:0] sat_q(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi, lo;
    hi = PW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    lo = -hi - PW'(64'sd1);
    if (v > hi) begin
      sat_q = hi[DW-1:0];
    end else if (v < lo) begin
      sat_q = lo[DW-1:0];
    end else begin
      sat_q = v[DW-1:0];
    end
  endfunction

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    mean_nxt      = mean_r;
    r_nxt         = r_r;
    v_nxt         = v_r;
    rsq_start_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (push) begin
          sum_nxt = sum_r + lnr_pkg::SUM_W'(in_item.data_value);
          if ((LW'(fill_r) + LW'(1)) >= len_eff) begin
            n_nxt     = LW'(fill_r) + LW'(1);
            state_nxt = S_MEAN;
          end else begin
            fill_nxt = fill_r + IW'(1);
          end
        end
      end
      S_MEAN:  state_nxt = S_MEAN2;
      S_MEAN2: begin
        mean_nxt  = sat_q(shv);
        idx_nxt   = '0;
        sumsq_nxt = '0;
        state_nxt = S_VRD;
      end
      S_VRD:  state_nxt = S_VMUL;
      S_VMUL: state_nxt = S_VACC;
      S_VACC: begin
        sumsq_nxt = sumsq_r + lnr_pkg::SUMSQ_W'(mul_p_r[32:0]);
        if (last_idx) begin
          state_nxt = S_VSCALE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_VRD;
        end
      end
      S_VSCALE: state_nxt = S_VSET;
      S_VSET: begin
        // Variance in Q16.16 plus one LSB of eps.
        v_nxt         = lnr_pkg::VAR_W'(rnd[54:16]) + lnr_pkg::VAR_W'(1);
        rsq_start_nxt = 1'b1;
        state_nxt     = S_RSQ;
      end
      S_RSQ: begin
        if (rsq_done) begin
          r_nxt     = rsq_root;
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: state_nxt = S_EM1;
      S_EM1: state_nxt = S_EM2;
      S_EM2: state_nxt = S_EM3;
      S_EM3: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.out_value    = sat_q(shv);
        out_item_nxt.out_position = lnr_pkg::POS_W'(idx_r);
        out_item_nxt.row_done     = last_idx;
        if (last_idx) begin
          fill_nxt  = '0;
          sum_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      sum_r        <= '0;
      rsq_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      row_length_r <= lnr_pkg::ROW_LENGTH_RST;
      recip_r      <= lnr_pkg::RECIP_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      rsq_start_r <= rsq_start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == lnr_pkg::CFG_ROW_LENGTH)) begin
        row_length_r <= cfg_data[LW-1:0];
      end
      if (cfg_we && (cfg_index == lnr_pkg::CFG_RECIP_LEN)) begin
        recip_r <= cfg_data;
      end
    end
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    sumsq_r    <= sumsq_nxt;
    mean_r     <= mean_nxt;
    r_r        <= r_nxt;
    v_r        <= v_nxt;
    mul_p_r    <= mul_p;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      row_mem[fill_r] <= in_item.data_value;
    end
    if (load) begin
      scale_mem[pos_wrap[in_item.position]]  <= in_item.weight_value;
      offset_mem[pos_wrap[in_item.position]] <= in_item.bias_value;
    end
    if (rd_en) begin
      row_q    <= row_mem[idx_r];
      scale_q  <= scale_mem[idx_r];
      offset_q <= offset_mem[idx_r];
    end
  end

  lnr_rsqrt u_rsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rsq_start_r),
    .operand (v_r),
    .done    (rsq_done),
    .root    (rsq_root)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The last result of a row leaves with the block already free again.
  a_last_frees : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.row_done |-> !busy)
    else $error("row_done shown while busy");

  // Results are spaced by the output pass, never in adjacent cycles.
  a_spacing : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  // The root unit reports only while the sequencer waits for it.
  a_rsq_wait : assert property (@(posedge clk) disable iff (!rst_n)
    rsq_done |-> (state_r == S_RSQ))
    else $error("root result outside its wait state");

endmodule

@@ src/lnr_rsqrt.sv @@
// ----------------------------------------------------------------------------
// lnr_rsqrt - iterative inverse square root
// Forms floor(sqrt(floor(2^48 / v))) with a restoring divider, one quotient
// bit a cycle, followed by a digit-by-digit square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module lnr_rsqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lnr_pkg::VAR_W-1:0]   operand,
  output logic                        done,
  output logic [lnr_pkg::ROOT_W-1:0]  root
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_SQRT = 2'd2;
  localparam logic [1:0] R_DONE = 2'd3;

  localparam int VW = lnr_pkg::VAR_W;
  localparam int QW = lnr_pkg::QUO_W;
  localparam int RW = lnr_pkg::ROOT_W;
  localparam int XW = 2 * RW;
  localparam int SW = RW + 2;

  logic [1:0]    state_r, state_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [SW-1:0] srem_r, srem_nxt;
  logic [RW-1:0] root_r, root_nxt;

  logic [VW:0]   rem_sh;
  logic [SW+1:0] rem2, trial;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    x_nxt     = x_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    rem_sh    = {rem_r, (cnt_r == 6'(QW - 1))};
    rem2      = {srem_r, x_r[XW-1:XW-2]};
    trial     = {1'b0, root_r, 2'b01};
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          div_nxt   = operand;
          rem_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = 6'(QW - 1);
          state_nxt = R_DIV;
        end
      end
      R_DIV: begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = VW'(rem_sh - {1'b0, div_r});
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[VW-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          x_nxt     = XW'(quo_nxt);
          srem_nxt  = '0;
          root_nxt  = '0;
          cnt_nxt   = 6'(RW - 1);
          state_nxt = R_SQRT;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      R_SQRT: begin
        x_nxt = {x_r[XW-3:0], 2'b00};
        if (rem2 >= trial) begin
          srem_nxt = SW'(rem2 - trial);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          srem_nxt = rem2[SW-1:0];
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = R_DONE;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      R_DONE: state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    x_r    <= x_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  assign done = (state_r == R_DONE);
  assign root = root_r;

endmodule
